// ----- rtl/core/ese_pkg.sv -----
// Shared types, codes and saturating helpers for the stiffness entry unit.
`default_nettype none

package ese_pkg;

	// Widths of the fixed-point operands and the shared multiplier.
	localparam int unsigned FIELD_W = 32;
	localparam int unsigned OPA_W   = FIELD_W + 1;
	localparam int unsigned ACC_W   = 64;
	localparam int unsigned PP_W    = 2 * OPA_W;
	localparam int unsigned FULL_W  = ACC_W + OPA_W + 1;
	localparam int unsigned ENTRY_W = 48;

	// Product steps run through the shared multiplier.
	typedef logic [2:0] op_t;
	localparam op_t OP_STRAIN = 3'd0;
	localparam op_t OP_SHEAR  = 3'd1;
	localparam op_t OP_VOL1   = 3'd2;
	localparam op_t OP_VOL2   = 3'd3;
	localparam op_t OP_TERM   = 3'd4;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic signed [ENTRY_W-1:0] ENTRY_MAX = {1'b0, {(ENTRY_W-1){1'b1}}};
	localparam logic signed [ENTRY_W-1:0] ENTRY_MIN = {1'b1, {(ENTRY_W-1){1'b0}}};

	// Signed 64-bit add that clips to the signed range.
	function automatic logic signed [ACC_W-1:0] sat_add(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic signed [ACC_W:0] s;
		s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
		if (s[ACC_W] != s[ACC_W-1]) begin
			return s[ACC_W] ? ACC_MIN : ACC_MAX;
		end
		return s[ACC_W-1:0];
	endfunction

endpackage

`default_nettype wire

// ----- rtl/core/elasticity_stiffness_entry_unit.sv -----
// Top level of the linear-elasticity stiffness entry unit.
//
// Each input word carries one gradient component pair of the trial and test
// functions plus the node data; words marked with the last-component flag
// close a quadrature node, and the word with tlast closes the basis pair and
// produces one 48-bit saturated entry word. All products go through a single
// 33x33 signed multiplier under a small sequencer: one 33x64 product runs
// through the steps low half, high half, recombine, and shift and clip. A
// plain word runs one product; a word that closes an active node runs four
// more products. The unit accepts no word while it works, and may wait in its
// done state while an earlier entry word is still held in the output register.
`default_nettype none

module elasticity_stiffness_entry_unit
	import ese_pkg::*;
#(
	parameter int unsigned FRAC_BITS = 16
) (
	input  wire          clk,
	input  wire          arst_n,
	input  wire          s_axis_tvalid,
	output logic         s_axis_tready,
	// grad_u_ij, grad_u_ji, grad_v_ij, grad_v_ji, jac_weight, shear_mod,
	// lame_first, div_u, div_v (32 bits each, lowest first)
	input  wire  [287:0] s_axis_tdata,
	// node_active, last_component
	input  wire  [1:0]   s_axis_tuser,
	// last_node
	input  wire          s_axis_tlast,
	output logic         m_axis_tvalid,
	input  wire          m_axis_tready,
	// entry_value (48 bits)
	output logic [47:0]  m_axis_tdata,
	// saturated
	output logic [0:0]   m_axis_tuser
);

	localparam int unsigned SH_STRAIN = FRAC_BITS + 2;
	localparam int unsigned SH_SHEAR  = FRAC_BITS - 1;
	localparam int unsigned SH_PLAIN  = FRAC_BITS;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LO   = 3'd1;
	localparam logic [2:0] S_HI   = 3'd2;
	localparam logic [2:0] S_ADD  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;
	localparam logic [2:0] S_DONE = 3'd5;

	logic [2:0] state_q;
	op_t        op_q;

	// Captured word.
	logic signed [OPA_W-1:0]   su_q;
	logic signed [OPA_W-1:0]   sv_q;
	logic signed [FIELD_W-1:0] jac_q;
	logic signed [FIELD_W-1:0] mu_q;
	logic signed [FIELD_W-1:0] lam_q;
	logic signed [FIELD_W-1:0] divu_q;
	logic signed [FIELD_W-1:0] divv_q;
	logic                      active_q;
	logic                      last_comp_q;
	logic                      last_node_q;

	// Accumulators and intermediates.
	logic signed [ACC_W-1:0]  strain_sum_q;
	logic signed [ACC_W-1:0]  entry_sum_q;
	logic signed [ACC_W-1:0]  shear_q;
	logic signed [ACC_W-1:0]  tmp_q;
	logic signed [PP_W-1:0]   prod_lo_q;
	logic signed [PP_W-1:0]   prod_hi_q;
	logic signed [FULL_W-1:0] full_q;

	logic signed [OPA_W-1:0]  opa;
	logic signed [ACC_W-1:0]  opb;
	logic signed [FULL_W-1:0] shifted;
	logic signed [ACC_W-1:0]  res;
	logic signed [PP_W-1:0]   mul_out;
	logic                     accept;
	logic                     out_free;
	logic                     entry_clip;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);

	// Operand and shift selection for the current product step.
	always_comb begin
		opa = su_q;
		opb = {{(ACC_W-OPA_W){sv_q[OPA_W-1]}}, sv_q};
		shifted = full_q >>> SH_STRAIN;
		unique case (op_q)
			OP_STRAIN: begin
				opa = su_q;
				opb = {{(ACC_W-OPA_W){sv_q[OPA_W-1]}}, sv_q};
				shifted = full_q >>> SH_STRAIN;
			end
			OP_SHEAR: begin
				opa = {mu_q[FIELD_W-1], mu_q};
				opb = strain_sum_q;
				shifted = full_q >>> SH_SHEAR;
			end
			OP_VOL1: begin
				opa = {lam_q[FIELD_W-1], lam_q};
				opb = {{(ACC_W-FIELD_W){divu_q[FIELD_W-1]}}, divu_q};
				shifted = full_q >>> SH_PLAIN;
			end
			OP_VOL2: begin
				opa = {divv_q[FIELD_W-1], divv_q};
				opb = tmp_q;
				shifted = full_q >>> SH_PLAIN;
			end
			OP_TERM: begin
				opa = {jac_q[FIELD_W-1], jac_q};
				opb = tmp_q;
				shifted = full_q >>> SH_PLAIN;
			end
			default: begin
				opa = su_q;
				opb = {{(ACC_W-OPA_W){sv_q[OPA_W-1]}}, sv_q};
				shifted = full_q >>> SH_STRAIN;
			end
		endcase
	end

	// The shared multiplier takes the low half of b, then its high half.
	always_comb begin
		if (state_q == S_LO) begin
			mul_out = opa * $signed({1'b0, opb[FIELD_W-1:0]});
		end else begin
			mul_out = opa * $signed({opb[ACC_W-1], opb[ACC_W-1:FIELD_W]});
		end
	end

	// Clip the floored product to the signed 64-bit range.
	always_comb begin
		if (shifted[FULL_W-1:ACC_W-1] == {(FULL_W-ACC_W+1){shifted[ACC_W-1]}}) begin
			res = shifted[ACC_W-1:0];
		end else begin
			res = full_q[FULL_W-1] ? ACC_MIN : ACC_MAX;
		end
	end

	assign entry_clip =
		entry_sum_q[ACC_W-1:ENTRY_W-1] != {(ACC_W-ENTRY_W+1){entry_sum_q[ACC_W-1]}};

	// Payload capture of the accepted word.
	always_ff @(posedge clk) begin
		if (accept) begin
			su_q   <= $signed({s_axis_tdata[31], s_axis_tdata[31:0]})
				+ $signed({s_axis_tdata[63], s_axis_tdata[63:32]});
			sv_q   <= $signed({s_axis_tdata[95], s_axis_tdata[95:64]})
				+ $signed({s_axis_tdata[127], s_axis_tdata[127:96]});
			jac_q  <= s_axis_tdata[159:128];
			mu_q   <= s_axis_tdata[191:160];
			lam_q  <= s_axis_tdata[223:192];
			divu_q <= s_axis_tdata[255:224];
			divv_q <= s_axis_tdata[287:256];
			active_q    <= s_axis_tuser[0];
			last_comp_q <= s_axis_tuser[1];
			last_node_q <= s_axis_tlast;
		end
		if (state_q == S_LO) begin
			prod_lo_q <= mul_out;
		end
		if (state_q == S_HI) begin
			prod_hi_q <= mul_out;
		end
		if (state_q == S_ADD) begin
			full_q <= ($signed({{(FULL_W-PP_W){prod_hi_q[PP_W-1]}}, prod_hi_q}) <<< FIELD_W)
				+ $signed({{(FULL_W-PP_W){1'b0}}, prod_lo_q[PP_W-1:0]})
				- $signed({{(FULL_W-PP_W){1'b0}}, prod_lo_q[PP_W-1], {(PP_W-1){1'b0}}})
				- $signed({{(FULL_W-PP_W){1'b0}}, prod_lo_q[PP_W-1], {(PP_W-1){1'b0}}});
		end
		if (state_q == S_FIN) begin
			if (op_q == OP_SHEAR) begin
				shear_q <= res;
			end
			if (op_q == OP_VOL1) begin
				tmp_q <= res;
			end
			if (op_q == OP_VOL2) begin
				tmp_q <= sat_add(shear_q, res);
			end
		end
		if (state_q == S_DONE && last_node_q && out_free) begin
			if (entry_clip) begin
				m_axis_tdata <= entry_sum_q[ACC_W-1] ? ENTRY_MIN : ENTRY_MAX;
			end else begin
				m_axis_tdata <= entry_sum_q[ENTRY_W-1:0];
			end
			m_axis_tuser <= entry_clip;
		end
	end

	// Sequencer, accumulators and output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			op_q          <= OP_STRAIN;
			strain_sum_q  <= '0;
			entry_sum_q   <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q    <= OP_STRAIN;
						state_q <= S_LO;
					end
				end
				S_LO: begin
					state_q <= S_HI;
				end
				S_HI: begin
					state_q <= S_ADD;
				end
				S_ADD: begin
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_LO;
					case (op_q)
						OP_STRAIN: begin
							strain_sum_q <= sat_add(strain_sum_q, res);
							if (last_comp_q && active_q) begin
								op_q <= OP_SHEAR;
							end else begin
								state_q <= S_DONE;
							end
						end
						OP_SHEAR: op_q <= OP_VOL1;
						OP_VOL1:  op_q <= OP_VOL2;
						OP_VOL2:  op_q <= OP_TERM;
						default: begin
							entry_sum_q <= sat_add(entry_sum_q, res);
							state_q     <= S_DONE;
						end
					endcase
				end
				S_DONE: begin
					// Close the node and, on the last node, hand over the entry.
					if (!last_node_q || out_free) begin
						if (last_comp_q || last_node_q) begin
							strain_sum_q <= '0;
						end
						if (last_node_q) begin
							entry_sum_q   <= '0;
							m_axis_tvalid <= 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// A clipped entry word always sits on one end of the 48-bit range.
	a_sat_extreme: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[0]) |->
			(m_axis_tdata == ENTRY_MAX || m_axis_tdata == ENTRY_MIN))
		else $error("saturated entry word is not at a range limit");

	// Emitting an entry clears both sums and raises the output valid.
	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && last_node_q && out_free) |=>
			(entry_sum_q == '0 && strain_sum_q == '0 && m_axis_tvalid))
		else $error("entry emission did not clear the sums");

	// A closed node leaves no strain contraction behind.
	a_node_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && last_comp_q && !last_node_q) |=> (strain_sum_q == '0))
		else $error("strain sum not cleared at end of node");

endmodule

`default_nettype wire

// ----- verif/elasticity_stiffness_entry_unit_test.sv -----
// Self-checking testbench for the stiffness entry unit: directed and random word streams.
`timescale 1ns / 1ps

module elasticity_stiffness_entry_unit_test
	import ese_pkg::*;
;

	localparam int FRAC = 16;
	localparam int WORD_TARGET = 1500;
	localparam int NOISE_WORDS = 120;
	localparam int TAIL_CYCLES = 40;
	localparam int CYCLE_LIMIT = 500000;
	localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;
	localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
	localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

	// One input word, split into its fields.
	typedef struct {
		logic signed [31:0] gu_ij, gu_ji, gv_ij, gv_ji;
		logic signed [31:0] jw, mu, lam, du, dv;
		logic active, last_comp, last_node;
	} word_t;

	// One expected entry word.
	typedef struct {
		logic [ENTRY_W-1:0] value;
		logic sat;
	} entry_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic [287:0] s_axis_tdata = '0;
	logic [1:0] s_axis_tuser = '0;
	logic s_axis_tlast = 1'b0;
	logic m_axis_tready = 1'b0;
	wire s_axis_tready;
	wire m_axis_tvalid;
	wire [47:0] m_axis_tdata;
	wire [0:0] m_axis_tuser;

	// Predictor state and the queue of entries still to come.
	logic signed [ACC_W-1:0] strain_acc = '0;
	logic signed [ACC_W-1:0] entry_acc = '0;
	entry_t expected_entries[$];

	int fail_count = 0;
	int sent_count = 0;
	int cycle_count = 0;
	int sink_wait = 0;
	bit idle_on = 1'b1;

	elasticity_stiffness_entry_unit #(.FRAC_BITS(FRAC)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tuser(m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Exact product, floor shift, then clip to the signed 64-bit range.
	function automatic logic signed [ACC_W-1:0] mul_floor(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b,
		input int unsigned sh
	);
		logic signed [127:0] wa;
		logic signed [127:0] wb;
		logic signed [127:0] q;
		wa = a;
		wb = b;
		q = (wa * wb) >>> sh;
		if (q[127:63] != {65{q[127]}}) begin
			return q[127] ? ACC_MIN : ACC_MAX;
		end
		return q[63:0];
	endfunction

	// Signed 64-bit sum clipped to the signed range.
	function automatic logic signed [ACC_W-1:0] add_clip(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b
	);
		logic signed [ACC_W:0] s;
		s = a + b;
		if (s > $signed({1'b0, ACC_MAX})) begin
			return ACC_MAX;
		end
		if (s < $signed({1'b1, ACC_MIN})) begin
			return ACC_MIN;
		end
		return s[ACC_W-1:0];
	endfunction

	// Advance the predictor by one accepted word; queue an entry on a last node.
	function automatic void accumulate_word(input word_t w);
		logic signed [ACC_W-1:0] su;
		logic signed [ACC_W-1:0] sv;
		logic signed [ACC_W-1:0] shear;
		logic signed [ACC_W-1:0] vol;
		entry_t e;
		su = w.gu_ij + w.gu_ji;
		sv = w.gv_ij + w.gv_ji;
		strain_acc = add_clip(strain_acc, mul_floor(su, sv, FRAC + 2));
		if (w.last_comp) begin
			if (w.active) begin
				shear = mul_floor(w.mu, strain_acc, FRAC - 1);
				vol = mul_floor(mul_floor(w.lam, w.du, FRAC), w.dv, FRAC);
				entry_acc = add_clip(entry_acc,
					mul_floor(w.jw, add_clip(shear, vol), FRAC));
			end
			strain_acc = '0;
		end
		if (w.last_node) begin
			e.sat = 1'b0;
			if (entry_acc > ENTRY_MAX) begin
				e.value = ENTRY_MAX;
				e.sat = 1'b1;
			end else if (entry_acc < ENTRY_MIN) begin
				e.value = ENTRY_MIN;
				e.sat = 1'b1;
			end else begin
				e.value = entry_acc[ENTRY_W-1:0];
			end
			expected_entries.push_back(e);
			strain_acc = '0;
			entry_acc = '0;
		end
	endfunction

	// Field values: mostly modest Q16.16 numbers, some full range, some corners.
	function automatic logic signed [31:0] draw_field();
		int pick;
		logic signed [31:0] v;
		pick = $urandom_range(0, 19);
		if (pick < 11) begin
			v = $urandom_range(0, 32'h0008_0000);
			if ($urandom_range(0, 1) != 0) begin
				v = -v;
			end
		end else if (pick < 17) begin
			v = $urandom;
		end else begin
			case ($urandom_range(0, 5))
				0: v = Q_MAX;
				1: v = Q_MIN;
				2: v = '0;
				3: v = -1;
				4: v = Q_ONE;
				default: v = 1;
			endcase
		end
		return v;
	endfunction

	function automatic word_t draw_word();
		word_t w;
		w.gu_ij = draw_field();
		w.gu_ji = draw_field();
		w.gv_ij = draw_field();
		w.gv_ji = draw_field();
		w.jw = draw_field();
		w.mu = draw_field();
		w.lam = draw_field();
		w.du = draw_field();
		w.dv = draw_field();
		w.active = ($urandom_range(0, 1) != 0);
		w.last_comp = ($urandom_range(0, 1) != 0);
		w.last_node = ($urandom_range(0, 1) != 0);
		return w;
	endfunction

	function automatic word_t make_word(
		input logic signed [31:0] gu, gu2, gv, gv2, jw, mu, lam, du, dv,
		input logic act, lc, ln
	);
		word_t w;
		w.gu_ij = gu;
		w.gu_ji = gu2;
		w.gv_ij = gv;
		w.gv_ji = gv2;
		w.jw = jw;
		w.mu = mu;
		w.lam = lam;
		w.du = du;
		w.dv = dv;
		w.active = act;
		w.last_comp = lc;
		w.last_node = ln;
		return w;
	endfunction

	// Send one word after a random gap; valid stays high when no gap follows.
	task automatic send_word(input word_t w);
		int gap;
		gap = idle_on ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {w.dv, w.du, w.lam, w.mu, w.jw, w.gv_ji, w.gv_ij, w.gu_ji, w.gu_ij};
		s_axis_tuser <= {w.last_comp, w.active};
		s_axis_tlast <= w.last_node;
		do @(posedge clk); while (!s_axis_tready);
		accumulate_word(w);
		sent_count++;
	endtask

	// One basis pair of well-formed nodes; a broken pair ends on an open node.
	task automatic send_pair(input int node_cnt, input int comp_cnt, input bit broken);
		word_t w;
		for (int n = 0; n < node_cnt; n++) begin
			for (int c = 0; c < comp_cnt; c++) begin
				w = draw_word();
				w.active = ($urandom_range(0, 4) != 0);
				w.last_comp = (c == comp_cnt - 1);
				w.last_node = (n == node_cnt - 1) && (c == comp_cnt - 1);
				if (broken && w.last_node) begin
					w.last_comp = 1'b0;
				end
				send_word(w);
			end
		end
	endtask

	task automatic do_reset();
		arst_n <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
	endtask

	// Single-word pairs with fields at their limits (both saturation signs), zero and near zero.
	task automatic test_field_extremes();
		send_word(make_word(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
			1'b1, 1'b1, 1'b1));
		send_word(make_word(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN,
			1'b1, 1'b1, 1'b1));
		send_word(make_word(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1, 1'b1, 1'b1));
		send_word(make_word(Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN,
			1'b1, 1'b1, 1'b1));
		send_word(make_word(-1, 1, -1, -1, -1, -1, -1, -1, -1, 1'b1, 1'b1, 1'b1));
	endtask

	// A plain three-component node with small values.
	task automatic test_plain_node();
		send_word(make_word(Q_ONE, 2 * Q_ONE, -Q_ONE, Q_ONE / 2, 0, 0, 0, 0, 0,
			1'b1, 1'b0, 1'b0));
		send_word(make_word(3 * Q_ONE, -Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0, 0,
			1'b1, 1'b0, 1'b0));
		send_word(make_word(Q_ONE / 4, Q_ONE, 2 * Q_ONE, -3 * Q_ONE, Q_ONE / 2, 5 * Q_ONE,
			3 * Q_ONE, Q_ONE, -2 * Q_ONE, 1'b1, 1'b1, 1'b1));
	endtask

	// An inactive node still sums strain but adds no node term.
	task automatic test_inactive_node();
		send_word(make_word(Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0, 0, 1'b0, 1'b0, 1'b0));
		send_word(make_word(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
			1'b0, 1'b1, 1'b0));
		send_word(make_word(2 * Q_ONE, 0, Q_ONE, 0, 0, 0, 0, 0, 0, 1'b1, 1'b0, 1'b0));
		send_word(make_word(Q_ONE, Q_ONE, -Q_ONE, Q_ONE, Q_ONE, 2 * Q_ONE, Q_ONE, Q_ONE,
			Q_ONE, 1'b1, 1'b1, 1'b1));
	endtask

	// Node data on words that do not close a node must be ignored.
	task automatic test_node_fields_ignored();
		send_word(make_word(Q_ONE, 0, Q_ONE, 0, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX,
			1'b1, 1'b0, 1'b0));
		send_word(make_word(0, Q_ONE, 0, -Q_ONE, Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN,
			1'b0, 1'b0, 1'b0));
		send_word(make_word(Q_ONE, Q_ONE, Q_ONE, 0, Q_ONE, Q_ONE, Q_ONE, 2 * Q_ONE, Q_ONE,
			1'b1, 1'b1, 1'b1));
	endtask

	// A last node that arrives before its last component drops the open strain.
	task automatic test_open_node_at_last();
		send_word(make_word(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
			1'b1, 1'b1, 1'b0));
		send_word(make_word(4 * Q_ONE, Q_ONE, Q_ONE, 2 * Q_ONE, 0, 0, 0, 0, 0,
			1'b1, 1'b0, 1'b0));
		send_word(make_word(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE,
			1'b1, 1'b0, 1'b1));
	endtask

	// The entry sum clips at 64 bits, then a large negative node pulls it back.
	task automatic test_overflow_recovery();
		send_word(make_word(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX,
			1'b1, 1'b1, 1'b0));
		send_word(make_word(Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN,
			1'b1, 1'b1, 1'b1));
	endtask

	// Mostly well-formed pairs with random content, idling switched on and off.
	task automatic test_random_pairs();
		int node_cnt;
		int comp_cnt;
		while (sent_count < WORD_TARGET - NOISE_WORDS) begin
			if ($urandom_range(0, 11) == 0) begin
				idle_on = !idle_on;
			end
			node_cnt = $urandom_range(1, 4);
			comp_cnt = $urandom_range(1, 6);
			send_pair(node_cnt, comp_cnt, $urandom_range(0, 9) == 0);
		end
		idle_on = 1'b1;
	endtask

	// Words with random flags in any order.
	task automatic test_random_flags();
		repeat (NOISE_WORDS) send_word(draw_word());
	endtask

	// Stop sending and wait until every entry has come back.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_entries.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	// Result sink: a random stall after each accepted entry word while idling is on.
	always @(posedge clk) begin : entry_sink
		int stall;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else if (m_axis_tvalid && m_axis_tready) begin
			stall = idle_on ? $urandom_range(0, 8) : 0;
			sink_wait <= stall;
			m_axis_tready <= (stall == 0);
		end else if (sink_wait != 0) begin
			sink_wait <= sink_wait - 1;
			m_axis_tready <= (sink_wait == 1);
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	// Compare each entry word with the oldest expectation.
	always @(posedge clk) begin : entry_check
		entry_t e;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_entries.size() == 0) begin
				$error("entry word with no expectation: entry_value %h saturated %b",
					m_axis_tdata, m_axis_tuser[0]);
				fail_count++;
			end else begin
				e = expected_entries.pop_front();
				if (m_axis_tdata !== e.value) begin
					$error("entry_value: expected %h, got %h", e.value, m_axis_tdata);
					fail_count++;
				end
				if (m_axis_tuser[0] !== e.sat) begin
					$error("saturated: expected %b, got %b", e.sat, m_axis_tuser[0]);
					fail_count++;
				end
			end
		end
	end

	// Watchdog on total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		do_reset();
		test_field_extremes();
		test_plain_node();
		test_inactive_node();
		test_node_fields_ignored();
		test_open_node_at_last();
		test_overflow_recovery();
		test_random_pairs();
		test_random_flags();
		wait_drained();
		if (expected_entries.size() != 0) begin
			$error("%0d entry words never arrived", expected_entries.size());
			fail_count++;
		end
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
